@@ hdl/cau_pkg.sv @@
// Shared constants, codes, types and helpers for the complex arithmetic unit.
// Used by cau_div and complex_arithmetic_unit; depends on nothing else.

package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int SHR       = DW - FRAC_BITS;
  localparam int DIV_STEPS = DW;
  // Prologue stages, divider stages and the output stage.
  localparam int PRE       = 4;
  localparam int NS        = PRE + DIV_STEPS + 1;

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]    func;
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          sat;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
  } side_t;

  // Saturates a 65-bit signed value to 32 bits; the top bit of the result is the flag.
  function automatic logic [DW:0] sat65(input logic [64:0] v);
    logic fits;
    fits = (v[64:DW-1] == '0) || (v[64:DW-1] == '1);
    if (fits) begin
      sat65 = {1'b0, v[DW-1:0]};
    end else begin
      sat65 = {1'b1, (v[64] ? VMIN : VMAX)};
    end
  endfunction

  // Applies sign and range to an unsigned quotient magnitude.
  function automatic logic [DW:0] sat_quot(input logic [DW-1:0] q, input logic neg,
                                           input logic ovf);
    if (neg) begin
      if (ovf || (q > {1'b1, {(DW-1){1'b0}}})) begin
        sat_quot = {1'b1, VMIN};
      end else begin
        sat_quot = {1'b0, DW'(0) - q};
      end
    end else begin
      if (ovf || q[DW-1]) begin
        sat_quot = {1'b1, VMAX};
      end else begin
        sat_quot = {1'b0, q};
      end
    end
  endfunction

endpackage

@@ hdl/cau_div.sv @@
// One lane of the pipelined restoring divider: one quotient bit per stage.
// Depends on cau_pkg.

module cau_div (
  input  logic                             clk_i,
  input  logic [cau_pkg::DIV_STEPS-1:0]    en_i,
  input  logic [63:0]                      den_i,
  input  logic [63:0]                      rem_i,
  input  logic [cau_pkg::DW-1:0]           low_i,
  output logic [cau_pkg::DW-1:0]           q_o
);
  import cau_pkg::*;

  logic [63:0]    den_q [DIV_STEPS];
  logic [63:0]    rem_q [DIV_STEPS];
  logic [DW-1:0]  low_q [DIV_STEPS];
  logic [DW-1:0]  q_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0]   den_in;
    logic [63:0]   rem_in;
    logic [DW-1:0] low_in;
    logic [DW-1:0] q_in;
    logic [64:0]   trial;
    logic [64:0]   diff;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign q_in   = '0;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign q_in   = q_q[k-1];
    end

    // The partial remainder stays below the divisor, so 65 bits hold the shifted value.
    assign trial = {rem_in, low_in[DW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        den_q[k] <= den_in;
        low_q[k] <= {low_in[DW-2:0], 1'b0};
        if (!diff[64]) begin
          rem_q[k] <= diff[63:0];
          q_q[k]   <= {q_in[DW-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[63:0];
          q_q[k]   <= {q_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = q_q[DIV_STEPS-1];

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply and divide of Q16.16 complex operands.
// One transaction enters per cycle while s_axis_tready is high. Every transaction passes
// through the two 32-stage restoring divider lanes, after four stages of products,
// sums, magnitudes and range checks. Each stage moves on its own, so bubbles close up
// while the output waits. Depends on cau_pkg, cau_div.

module complex_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // res_re, res_im
  output logic [1:0]   m_axis_tuser   // status
);
  import cau_pkg::*;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int j = NS - 1; j >= 0; j--) begin
      rdy[j] = !v_q[j] || rdy[j+1];
    end
    for (int j = 0; j < NS; j++) begin
      if (rdy[j]) begin
        v_d[j] = (j == 0) ? s_axis_tvalid : v_q[(j == 0) ? 0 : j - 1];
      end else begin
        v_d[j] = v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[0];

  // Stage 0: products and add/subtract.
  logic signed [DW-1:0] ar, ai, br, bi;
  logic [64:0]          as_re, as_im;
  logic [DW:0]          sr_d, si_d;
  logic [1:0]           func0_q;
  logic [DW-1:0]        asre0_q, asim0_q;
  logic                 assat0_q;
  logic signed [63:0]   p1_q, p2_q, p3_q, p4_q, sqr_q, sqi_q;

  assign ar = s_axis_tdata[31:0];
  assign ai = s_axis_tdata[63:32];
  assign br = s_axis_tdata[95:64];
  assign bi = s_axis_tdata[127:96];

  always_comb begin
    if (s_axis_tuser == FN_SUB) begin
      as_re = {{33{ar[DW-1]}}, ar} - {{33{br[DW-1]}}, br};
      as_im = {{33{ai[DW-1]}}, ai} - {{33{bi[DW-1]}}, bi};
    end else begin
      as_re = {{33{ar[DW-1]}}, ar} + {{33{br[DW-1]}}, br};
      as_im = {{33{ai[DW-1]}}, ai} + {{33{bi[DW-1]}}, bi};
    end
    sr_d = sat65(as_re);
    si_d = sat65(as_im);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      func0_q  <= s_axis_tuser;
      asre0_q  <= sr_d[DW-1:0];
      asim0_q  <= si_d[DW-1:0];
      assat0_q <= sr_d[DW] | si_d[DW];
      p1_q     <= 64'(ar) * 64'(br);
      p2_q     <= 64'(ai) * 64'(bi);
      p3_q     <= 64'(ar) * 64'(bi);
      p4_q     <= 64'(ai) * 64'(br);
      sqr_q    <= 64'(br) * 64'(br);
      sqi_q    <= 64'(bi) * 64'(bi);
    end
  end

  // Stage 1: exact sums of the products.
  logic [1:0]    func1_q;
  logic [DW-1:0] asre1_q, asim1_q;
  logic          assat1_q;
  logic [64:0]   mr_q, mi_q, nre_q, nim_q;
  logic [63:0]   den1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      func1_q  <= func0_q;
      asre1_q  <= asre0_q;
      asim1_q  <= asim0_q;
      assat1_q <= assat0_q;
      mr_q     <= {p1_q[63], p1_q} - {p2_q[63], p2_q};
      mi_q     <= {p3_q[63], p3_q} + {p4_q[63], p4_q};
      nre_q    <= {p1_q[63], p1_q} + {p2_q[63], p2_q};
      nim_q    <= {p4_q[63], p4_q} - {p3_q[63], p3_q};
      den1_q   <= sqr_q + sqi_q;
    end
  end

  // Stage 2: scale the product sums, take numerator magnitudes.
  logic [64:0] mr_sh, mi_sh, nre_neg, nim_neg;
  logic [DW:0] msr, msi;
  side_t       side2_d;
  side_t       side_q [PRE-2:NS-2];
  logic [63:0] magre_q, magim_q, den2_q;

  always_comb begin
    mr_sh   = $signed(mr_q) >>> FRAC_BITS;
    mi_sh   = $signed(mi_q) >>> FRAC_BITS;
    msr     = sat65(mr_sh);
    msi     = sat65(mi_sh);
    nre_neg = 65'd0 - nre_q;
    nim_neg = 65'd0 - nim_q;
    side2_d = '0;
    side2_d.func   = func1_q;
    side2_d.neg_re = nre_q[64];
    side2_d.neg_im = nim_q[64];
    side2_d.dz     = (den1_q == '0);
    if (func1_q == FN_MUL) begin
      side2_d.res_re = msr[DW-1:0];
      side2_d.res_im = msi[DW-1:0];
      side2_d.sat    = msr[DW] | msi[DW];
    end else begin
      side2_d.res_re = asre1_q;
      side2_d.res_im = asim1_q;
      side2_d.sat    = assat1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      side_q[2] <= side2_d;
      magre_q   <= nre_q[64] ? nre_neg[63:0] : nre_q[63:0];
      magim_q   <= nim_q[64] ? nim_neg[63:0] : nim_q[63:0];
      den2_q    <= den1_q;
    end
  end

  // Stage 3: quotient range check and divider set-up.
  logic [63:0]   hire, hiim;
  logic [63:0]   rre_q, rim_q, den3_q;
  logic [DW-1:0] lre_q, lim_q;
  side_t         side3_d;

  assign hire = magre_q >> SHR;
  assign hiim = magim_q >> SHR;

  always_comb begin
    side3_d        = side_q[2];
    side3_d.ovf_re = hire >= den2_q;
    side3_d.ovf_im = hiim >= den2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      side_q[3]        <= side3_d;
      rre_q            <= hire;
      rim_q            <= hiim;
      lre_q            <= {magre_q[SHR-1:0], {FRAC_BITS{1'b0}}};
      lim_q            <= {magim_q[SHR-1:0], {FRAC_BITS{1'b0}}};
      den3_q           <= den2_q;
    end
  end

  // Stages 4 to 35: divider lanes, side data travels alongside.
  logic [DW-1:0] qre, qim;

  cau_div u_div_re (
    .clk_i (clk_i),
    .en_i  (rdy[PRE +: DIV_STEPS]),
    .den_i (den3_q),
    .rem_i (rre_q),
    .low_i (lre_q),
    .q_o   (qre)
  );

  cau_div u_div_im (
    .clk_i (clk_i),
    .en_i  (rdy[PRE +: DIV_STEPS]),
    .den_i (den3_q),
    .rem_i (rim_q),
    .low_i (lim_q),
    .q_o   (qim)
  );

  for (genvar j = PRE; j < NS - 1; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // Output stage.
  side_t       sl;
  logic [DW:0] dre, dim;
  logic [DW-1:0] ore_q, oim_q;
  logic [1:0]    ost_q;

  assign sl  = side_q[NS-2];
  assign dre = sat_quot(qre, sl.neg_re, sl.ovf_re);
  assign dim = sat_quot(qim, sl.neg_im, sl.ovf_im);

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      if (sl.func == FN_DIV) begin
        if (sl.dz) begin
          ore_q <= '0;
          oim_q <= '0;
          ost_q <= ST_DZ;
        end else begin
          ore_q <= dre[DW-1:0];
          oim_q <= dim[DW-1:0];
          ost_q <= (dre[DW] | dim[DW]) ? ST_SAT : ST_OK;
        end
      end else begin
        ore_q <= sl.res_re;
        oim_q <= sl.res_im;
        ost_q <= sl.sat ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_axis_tvalid = v_q[NS-1];
  assign m_axis_tdata  = {oim_q, ore_q};
  assign m_axis_tuser  = ost_q;

  // Input is refused only when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ((&v_q) && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_DZ)) |-> (m_axis_tdata == '0))
    else $error("divide by zero with a nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_SAT)) |->
      ((ore_q == VMAX) || (ore_q == VMIN) || (oim_q == VMAX) || (oim_q == VMIN)))
    else $error("saturation reported without a limit value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined status code");

endmodule

@@ tb/tb_complex_arithmetic_unit.sv @@
// Self-checking testbench for complex_arithmetic_unit: directed and random transactions
// checked against an in-bench Q16.16 predictor. Depends on cau_pkg and the RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int N_RANDOM  = 1150;
  localparam int MAX_CYCLE = 600000;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] im;
    logic [31:0] re;
  } cplx_res_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [31:0] ar;
    logic [31:0] ai;
    logic [31:0] br;
    logic [31:0] bi;
    logic        known;
    cplx_res_t   res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // a_re, a_im, b_re, b_im
  logic [1:0]   s_axis_tuser = '0;  // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;       // res_re, res_im
  logic [1:0]   m_axis_tuser;       // status

  cplx_res_t pending_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 29;
  int        recv_stall_pct = 69;

  complex_arithmetic_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [31:0] clip32(input logic signed [65:0] v, inout logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return VMIN;
    end
    return v[31:0];
  endfunction

  // Exact quotient n * 2^FRAC_BITS / den, truncated toward zero, then saturated.
  function automatic logic [31:0] fixed_quot(input logic signed [65:0] n,
                                             input logic [65:0] den, inout logic sat);
    logic        neg;
    logic [65:0] mag;
    logic [95:0] q;
    neg = n < 0;
    mag = neg ? -n : n;
    q = (96'(mag) << FRAC_BITS) / 96'(den);
    if (neg) begin
      if (q > 96'h8000_0000) begin
        sat = 1'b1;
        return VMIN;
      end
      return 32'd0 - q[31:0];
    end
    if (q > 96'h7fff_ffff) begin
      sat = 1'b1;
      return VMAX;
    end
    return q[31:0];
  endfunction

  function automatic cplx_res_t cplx_eval(input logic [1:0] fn, input logic [31:0] ar,
                                          input logic [31:0] ai, input logic [31:0] br,
                                          input logic [31:0] bi);
    logic signed [65:0] a_r, a_i, b_r, b_i, num_re, num_im;
    logic [65:0]        den;
    logic               sat;
    cplx_res_t          r;
    a_r = 66'($signed(ar));
    a_i = 66'($signed(ai));
    b_r = 66'($signed(br));
    b_i = 66'($signed(bi));
    sat = 1'b0;
    r = '0;
    case (fn)
      FN_ADD: begin
        r.re = clip32(a_r + b_r, sat);
        r.im = clip32(a_i + b_i, sat);
      end
      FN_SUB: begin
        r.re = clip32(a_r - b_r, sat);
        r.im = clip32(a_i - b_i, sat);
      end
      FN_MUL: begin
        // Truncation of the combined sums rounds toward minus infinity.
        r.re = clip32((a_r * b_r - a_i * b_i) >>> FRAC_BITS, sat);
        r.im = clip32((a_r * b_i + a_i * b_r) >>> FRAC_BITS, sat);
      end
      default: begin
        den = b_r * b_r + b_i * b_i;
        if (den == 0) begin
          r.st = ST_DZ;
        end else begin
          num_re = a_r * b_r + a_i * b_i;
          num_im = a_i * b_r - a_r * b_i;
          r.re = fixed_quot(num_re, den, sat);
          r.im = fixed_quot(num_im, den, sat);
        end
      end
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cplx_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== want.re) begin
          $error("res_re expected %h actual %h", want.re, m_axis_tdata[31:0]);
          err_cnt++;
        end
        if (m_axis_tdata[63:32] !== want.im) begin
          $error("res_im expected %h actual %h", want.im, m_axis_tdata[63:32]);
          err_cnt++;
        end
        if (m_axis_tuser !== want.st) begin
          $error("status expected %0d actual %0d", want.st, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Drives one transaction and queues its expected result once it is taken.
  task automatic send_op(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = row.fn;
    s_axis_tdata = {row.bi, row.br, row.ai, row.ar};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(row.known ? row.res : cplx_eval(row.fn, row.ar, row.ai, row.br,
                                                        row.bi));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return $urandom_range(32'h001f_ffff) - 32'h0010_0000;
      7: return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
      default: begin
        case ($urandom_range(5))
          0: return VMAX;
          1: return VMIN;
          2: return 32'h0001_0000;
          3: return 32'hffff_ffff;
          4: return 32'h0000_0001;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  stim_row_t dir_tab[14] = '{
    '{FN_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 32'h0}},
    '{FN_ADD, VMAX, 32'h0, 32'h1, 32'h0, 1'b1, '{ST_SAT, 32'h0, VMAX}},
    '{FN_SUB, VMIN, 32'h5, 32'h1, 32'h5, 1'b1, '{ST_SAT, 32'h0, VMIN}},
    '{FN_SUB, 32'h0, VMAX, 32'h0, VMIN, 1'b1, '{ST_SAT, VMAX, 32'h0}},
    '{FN_MUL, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 1'b1, '{ST_OK, 32'h0, 32'h1_0000}},
    '{FN_MUL, VMIN, VMIN, VMIN, VMIN, 1'b0, '0},
    '{FN_MUL, VMAX, VMAX, VMAX, VMAX, 1'b0, '0},
    '{FN_MUL, 32'hffff_ffff, 32'h3, 32'h1, 32'hffff_fffd, 1'b0, '0},
    '{FN_DIV, 32'h1234_5678, 32'h9abc_def0, 32'h0, 32'h0, 1'b1, '{ST_DZ, 32'h0, 32'h0}},
    '{FN_DIV, VMAX, VMIN, 32'h0, 32'h0, 1'b1, '{ST_DZ, 32'h0, 32'h0}},
    '{FN_DIV, 32'h0003_8000, 32'hfffe_4000, 32'h1_0000, 32'h0, 1'b1,
      '{ST_OK, 32'hfffe_4000, 32'h0003_8000}},
    '{FN_DIV, 32'h1_0000, 32'h0, 32'h1, 32'h0, 1'b0, '0},
    '{FN_DIV, VMIN, VMAX, 32'hffff_ffff, 32'h1, 1'b0, '0},
    '{FN_DIV, 32'hfffd_0000, 32'h0002_0000, 32'h0000_c000, 32'hffff_6000, 1'b0, '0}
  };

  initial begin
    stim_row_t row;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) send_op(dir_tab[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) begin
        send_idle_pct = 69;
        recv_stall_pct = 29;
      end
      if (n == 800) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // Let the pipeline drain completely once before carrying on.
      if (n == 600) begin
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      row = '0;
      row.fn = 2'($urandom_range(3));
      row.ar = pick_operand();
      row.ai = pick_operand();
      row.br = pick_operand();
      row.bi = pick_operand();
      if (row.fn == FN_DIV && $urandom_range(19) == 0) begin
        row.br = '0;
        row.bi = '0;
      end
      send_op(row);
    end
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (NS + 20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/cau_pkg.sv
hdl/cau_div.sv
hdl/complex_arithmetic_unit.sv
tb/tb_complex_arithmetic_unit.sv
